@@ sv/ssd4_pkg.sv @@
// ----------------------------------------------------------------------------
// ssd4_pkg
// Shared types, widths and the decimal segment table for the four-digit
// multiplexed seven-segment driver.
// ----------------------------------------------------------------------------
package ssd4_pkg;

  localparam int NUM_DIGITS  = 4;
  localparam int IDX_W       = 2;
  localparam int DIGIT_W     = 4;
  localparam int VALUE_W     = 14;
  localparam int SEG_W       = 7;
  localparam int DWELL_W     = 16;

  localparam logic [DWELL_W-1:0] DWELL_RESET = 16'd2;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digit_vec_t;

  typedef struct packed {
    logic             valid;
    logic             latch;
    logic [IDX_W-1:0] idx;
  } scan_req_t;

  function automatic logic [SEG_W-1:0] seg_pattern(input logic [DIGIT_W-1:0] d);
    logic [SEG_W-1:0] p;
    case (d)
      4'd0:    p = 7'h3F;
      4'd1:    p = 7'h06;
      4'd2:    p = 7'h5B;
      4'd3:    p = 7'h4F;
      4'd4:    p = 7'h66;
      4'd5:    p = 7'h6D;
      4'd6:    p = 7'h7D;
      4'd7:    p = 7'h07;
      4'd8:    p = 7'h7F;
      4'd9:    p = 7'h6F;
      default: p = '0;
    endcase
    return p;
  endfunction

endpackage

@@ sv/ssd4_scan.sv @@
// ----------------------------------------------------------------------------
// ssd4_scan
// Dwell counter and digit index of the scan, plus the input register that
// holds one accepted tick until the decode stage takes it.
// ----------------------------------------------------------------------------
module ssd4_scan (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          take,
  input  logic [ssd4_pkg::VALUE_W-1:0]  value,
  input  logic [ssd4_pkg::DWELL_W-1:0]  dwell_ticks,
  output ssd4_pkg::scan_req_t           req,
  output logic [ssd4_pkg::VALUE_W-1:0]  value_q
);

  logic [ssd4_pkg::IDX_W-1:0]   digit_index;
  logic [ssd4_pkg::IDX_W-1:0]   digit_index_next;
  logic [ssd4_pkg::DWELL_W-1:0] dwell_count;
  logic [ssd4_pkg::DWELL_W-1:0] dwell_count_next;
  logic [ssd4_pkg::DWELL_W-1:0] dwell_eff;
  logic [ssd4_pkg::DWELL_W-1:0] count_inc;
  logic                         pass_start;

  always_comb begin
    dwell_eff  = (dwell_ticks == '0) ? ssd4_pkg::DWELL_W'(1) : dwell_ticks;
    count_inc  = dwell_count + ssd4_pkg::DWELL_W'(1);
    pass_start = (digit_index == '0) && (dwell_count == '0);
    if (count_inc == '0 || count_inc >= dwell_eff) begin
      dwell_count_next = '0;
      if (digit_index == ssd4_pkg::IDX_W'(ssd4_pkg::NUM_DIGITS - 1)) begin
        digit_index_next = '0;
      end else begin
        digit_index_next = digit_index + ssd4_pkg::IDX_W'(1);
      end
    end else begin
      dwell_count_next = count_inc;
      digit_index_next = digit_index;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      digit_index <= '0;
      dwell_count <= '0;
      req         <= '0;
      value_q     <= '0;
    end else begin
      if (accept) begin
        digit_index <= digit_index_next;
        dwell_count <= dwell_count_next;
        req.valid   <= 1'b1;
        req.latch   <= pass_start;
        req.idx     <= digit_index;
        value_q     <= value;
      end else if (take) begin
        req.valid   <= 1'b0;
      end
    end
  end

endmodule

@@ sv/ssd4_decode.sv @@
// ----------------------------------------------------------------------------
// ssd4_decode
// Splits the held value into decimal digits by reciprocal multiplication,
// picks the digit being shown and maps it to segments and a digit enable.
// ----------------------------------------------------------------------------
module ssd4_decode (
  input  ssd4_pkg::scan_req_t                 req,
  input  logic [ssd4_pkg::VALUE_W-1:0]        value_q,
  input  ssd4_pkg::digit_vec_t                latched_digits,
  output ssd4_pkg::digit_vec_t                fresh_digits,
  output logic [ssd4_pkg::SEG_W-1:0]          segments_next,
  output logic [ssd4_pkg::NUM_DIGITS-1:0]     enable_next
);

  logic [27:0] th_prod;
  logic [4:0]  th_q;
  logic [27:0] h_prod;
  logic [7:0]  h_q;
  logic [30:0] t_prod;
  logic [10:0] t_q;
  ssd4_pkg::digit_vec_t       shown;
  logic [ssd4_pkg::DIGIT_W-1:0] digit;

  always_comb begin
    th_prod = 28'(value_q) * 28'd8389;
    th_q    = th_prod[27:23];
    h_prod  = 28'(value_q) * 28'd10486;
    h_q     = h_prod[27:20];
    t_prod  = 31'(value_q) * 31'd104858;
    t_q     = t_prod[30:20];

    fresh_digits[0] = (th_q >= 5'd10) ? 4'(th_q - 5'd10) : th_q[3:0];
    fresh_digits[1] = 4'(h_q - 8'(th_q) * 8'd10);
    fresh_digits[2] = 4'(t_q - 11'(h_q) * 11'd10);
    fresh_digits[3] = 4'(value_q - 14'(t_q) * 14'd10);

    shown         = req.latch ? fresh_digits : latched_digits;
    digit         = shown[req.idx];
    segments_next = ssd4_pkg::seg_pattern(digit);
    enable_next   = '0;
    enable_next[req.idx] = 1'b1;
  end

endmodule

@@ sv/four_digit_seven_segment_mux_unit.sv @@
// ----------------------------------------------------------------------------
// four_digit_seven_segment_mux_unit
// An accepted tick goes through the input register, then the result register.
// Throughput: one tick per cycle unless out_stall holds, set by the single decode
// pass between the two registers. Reset (rst, synchronous) clears the scan
// position, the latched digits and the valid flags, and sets dwell to 2.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_mux_unit (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ssd4_pkg::DWELL_W-1:0]       cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [ssd4_pkg::VALUE_W-1:0]       value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [ssd4_pkg::SEG_W-1:0]         segments,
  output logic [ssd4_pkg::NUM_DIGITS-1:0]    digit_enable
);

  logic [ssd4_pkg::DWELL_W-1:0]     dwell_ticks;
  ssd4_pkg::scan_req_t              req;
  logic [ssd4_pkg::VALUE_W-1:0]     value_q;
  ssd4_pkg::digit_vec_t             latched_digits;
  ssd4_pkg::digit_vec_t             fresh_digits;
  logic [ssd4_pkg::SEG_W-1:0]       segments_next;
  logic [ssd4_pkg::NUM_DIGITS-1:0]  enable_next;
  logic                             take;
  logic                             accept;

  assign cfg_ready = 1'b1;
  assign take      = req.valid && (!out_valid || !out_stall);
  assign in_stall  = req.valid && !take;
  assign accept    = in_valid && !in_stall;

  ssd4_scan u_scan (
    .clk         (clk),
    .rst         (rst),
    .accept      (accept),
    .take        (take),
    .value       (value),
    .dwell_ticks (dwell_ticks),
    .req         (req),
    .value_q     (value_q)
  );

  ssd4_decode u_decode (
    .req            (req),
    .value_q        (value_q),
    .latched_digits (latched_digits),
    .fresh_digits   (fresh_digits),
    .segments_next  (segments_next),
    .enable_next    (enable_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      dwell_ticks    <= ssd4_pkg::DWELL_RESET;
      latched_digits <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        dwell_ticks <= cfg_data;
      end
      if (take && req.latch) begin
        latched_digits <= fresh_digits;
      end
      if (take) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // hold the result while stalled
  always_ff @(posedge clk) begin
    if (take) begin
      segments     <= segments_next;
      digit_enable <= enable_next;
    end
  end

endmodule

@@ sim/seg_mux_checker.sv @@
// ----------------------------------------------------------------------------
// seg_mux_checker
// Watches the tick, dwell and result channels of the four-digit display mux.
// It keeps its own scan position, dwell counter and latched digits, predicts
// the segment pattern and digit enable of every accepted tick, and compares
// them in order with the results the block hands out.
// ----------------------------------------------------------------------------
module seg_mux_checker (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [ssd4_pkg::DWELL_W-1:0]      cfg_data,
  input  logic                              in_valid,
  input  logic                              in_stall,
  input  logic [ssd4_pkg::VALUE_W-1:0]      value,
  input  logic                              out_valid,
  input  logic                              out_stall,
  input  logic [ssd4_pkg::SEG_W-1:0]        segments,
  input  logic [ssd4_pkg::NUM_DIGITS-1:0]   digit_enable,
  output int                                fail_count,
  output int                                pending,
  output int                                results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ssd4_pkg::SEG_W-1:0]      segments;
    logic [ssd4_pkg::NUM_DIGITS-1:0] digit_enable;
  } shown_t;

  localparam logic [ssd4_pkg::SEG_W-1:0] DECIMAL_SEGS [10] = '{
    7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
  };

  logic [ssd4_pkg::DWELL_W-1:0] dwell_setting;
  logic [ssd4_pkg::IDX_W-1:0]   scan_pos;
  logic [ssd4_pkg::DWELL_W-1:0] ticks_on_digit;
  logic [ssd4_pkg::DIGIT_W-1:0] held_digits [ssd4_pkg::NUM_DIGITS];
  shown_t                       shown_q [$];

  function automatic shown_t scan_tick(input logic [ssd4_pkg::VALUE_W-1:0] v);
    shown_t                       r;
    int unsigned                  n;
    int unsigned                  dwell;
    logic [ssd4_pkg::DWELL_W-1:0] next_count;
    dwell = (dwell_setting == '0) ? 1 : 32'(dwell_setting);
    n = 32'(v);
    if (scan_pos == '0 && ticks_on_digit == '0) begin
      held_digits[0] = ssd4_pkg::DIGIT_W'((n / 1000) % 10);
      held_digits[1] = ssd4_pkg::DIGIT_W'((n / 100) % 10);
      held_digits[2] = ssd4_pkg::DIGIT_W'((n / 10) % 10);
      held_digits[3] = ssd4_pkg::DIGIT_W'(n % 10);
    end
    r.segments     = DECIMAL_SEGS[held_digits[scan_pos]];
    r.digit_enable = ssd4_pkg::NUM_DIGITS'(1) << scan_pos;
    next_count = ticks_on_digit + ssd4_pkg::DWELL_W'(1);
    if (next_count == '0 || next_count >= dwell) begin
      ticks_on_digit = '0;
      scan_pos       = scan_pos + ssd4_pkg::IDX_W'(1);
    end else begin
      ticks_on_digit = next_count;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    shown_t exp_r;
    if (rst) begin
      dwell_setting  = ssd4_pkg::DWELL_RESET;
      scan_pos       = '0;
      ticks_on_digit = '0;
      foreach (held_digits[k]) held_digits[k] = '0;
      shown_q.delete();
    end else begin
      if (out_valid && !out_stall) begin
        results_seen++;
        if (shown_q.size() == 0) begin
          $error("result with no pending request: segments %h digit_enable %h",
                 segments, digit_enable);
          fail_count++;
        end else begin
          exp_r = shown_q.pop_front();
          if (segments !== exp_r.segments) begin
            $error("segments mismatch: expected %h actual %h", exp_r.segments, segments);
            fail_count++;
          end
          if (digit_enable !== exp_r.digit_enable) begin
            $error("digit_enable mismatch: expected %h actual %h",
                   exp_r.digit_enable, digit_enable);
            fail_count++;
          end
        end
      end
      if (cfg_valid && cfg_ready) dwell_setting = cfg_data;
      if (in_valid && !in_stall) shown_q.push_back(scan_tick(value));
    end
    pending = shown_q.size();
  end

endmodule

@@ sim/four_digit_seven_segment_mux_unit_tb.sv @@
// ----------------------------------------------------------------------------
// four_digit_seven_segment_mux_unit_tb
// Drives display ticks and dwell settings into the four-digit mux, with random
// gaps and output stalls and one long output hold, and lets seg_mux_checker
// judge every result. Covers default, zero, one, lowered and maximum dwell.
// ----------------------------------------------------------------------------
module four_digit_seven_segment_mux_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 100000;
  localparam int HOLD_CYCLES  = 80;
  localparam int PRESSURE_AT  = 300;
  localparam int DRAIN_CYCLES = 4;

  logic                              clk;
  logic                              rst;
  logic                              cfg_valid;
  logic                              cfg_ready;
  logic [ssd4_pkg::DWELL_W-1:0]      cfg_data;
  logic                              in_valid;
  logic                              in_stall;
  logic [ssd4_pkg::VALUE_W-1:0]      value;
  logic                              out_valid;
  logic                              out_stall;
  logic [ssd4_pkg::SEG_W-1:0]        segments;
  logic [ssd4_pkg::NUM_DIGITS-1:0]   digit_enable;

  int fail_count;
  int pending;
  int results_seen;
  int cycle_count;
  int ticks_sent;
  int dwell_writes;

  four_digit_seven_segment_mux_unit u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .digit_enable (digit_enable)
  );

  seg_mux_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .value        (value),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .segments     (segments),
    .digit_enable (digit_enable),
    .fail_count   (fail_count),
    .pending      (pending),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("four_digit_seven_segment_mux_unit_tb: FAIL");
      $finish;
    end
  end

  function automatic logic [ssd4_pkg::VALUE_W-1:0] random_value();
    logic [ssd4_pkg::VALUE_W-1:0] v;
    if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 3))
        0:       v = '0;
        1:       v = '1;
        2:       v = 14'd9999;
        default: v = 14'd10000;
      endcase
    end else begin
      v = ssd4_pkg::VALUE_W'($urandom_range(0, 16383));
    end
    return v;
  endfunction

  // Call at a falling edge; returns at the falling edge after acceptance.
  task automatic send_tick(input logic [ssd4_pkg::VALUE_W-1:0] v);
    int unsigned gap;
    gap = ((ticks_sent % 160) < 30) ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    value    <= v;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
    @(negedge clk);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_dwell(input logic [ssd4_pkg::DWELL_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    dwell_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  initial begin : result_sink
    int unsigned hold;
    int unsigned taken;
    bit          pressed;
    out_stall = 1'b0;
    taken     = 0;
    pressed   = 1'b0;
    @(negedge clk);
    forever begin
      if (!pressed && taken >= PRESSURE_AT) begin
        hold    = HOLD_CYCLES;
        pressed = 1'b1;
      end else if ((taken % 140) < 25) begin
        hold = 0;
      end else begin
        hold = $urandom_range(0, 5);
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      taken++;
      @(negedge clk);
    end
  end

  initial begin : stimulus
    logic [ssd4_pkg::DWELL_W-1:0] d;
    logic [ssd4_pkg::VALUE_W-1:0] pass_values [3];
    rst       = 1'b1;
    in_valid  = 1'b0;
    value     = '0;
    cfg_valid = 1'b0;
    cfg_data  = '0;
    repeat (11) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // one full pass at the reset dwell of two
    send_tick(14'd16383);
    repeat (7) send_tick(random_value());

    // dwell of one: each pass latches a new value, later ticks do not change it
    settle();
    write_dwell(16'd1);
    pass_values = '{14'd0, 14'd9999, 14'd10000};
    foreach (pass_values[k]) begin
      send_tick(pass_values[k]);
      repeat (3) send_tick(random_value());
    end

    // zero dwell acts as one
    settle();
    write_dwell(16'd0);
    send_tick(14'd5678);
    repeat (3) send_tick(random_value());

    // lower the dwell below the ticks already spent on a digit
    settle();
    write_dwell(16'd6);
    repeat (3) send_tick(14'd4321);
    settle();
    write_dwell(16'd2);
    repeat (2) send_tick(random_value());

    for (int p = 0; p < 10; p++) begin
      case (p)
        0:       d = 16'hFFFF;
        1:       d = 16'd1;
        2:       d = 16'd0;
        default: begin
          if ($urandom_range(0, 5) == 0) d = ssd4_pkg::DWELL_W'($urandom_range(7, 300));
          else d = ssd4_pkg::DWELL_W'($urandom_range(1, 6));
        end
      endcase
      settle();
      write_dwell(d);
      repeat ((p == 0) ? 40 : 85) send_tick(random_value());
    end

    settle();
    $display("Sent %0d ticks over %0d dwell writes (zero, one, lowered, 65535),",
             ticks_sent, dwell_writes);
    $display("with random gaps, stalls and one long output hold; %0d results checked.",
             results_seen);
    if (fail_count == 0 && pending == 0) begin
      $display("four_digit_seven_segment_mux_unit_tb: PASS");
    end else begin
      $display("four_digit_seven_segment_mux_unit_tb: FAIL");
    end
    $finish;
  end

endmodule
